@@ hdl/frs8_pkg.sv @@
// ----------------------------------------------------------------------------
// frs8_pkg
// Shared types and constants for the sum-8 framed packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package frs8_pkg;

    // Default largest payload a frame may carry.
    localparam int MAX_PAYLOAD_DEF = 30;

    // Request kinds on the input channel.
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Configuration register indexes and reset values.
    localparam logic       CFG_SYNC_FIRST  = 1'b0;
    localparam logic       CFG_SYNC_SECOND = 1'b1;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hAF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] msg_id;
        logic [4:0] payload_len;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_SUM,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sum_load;
        logic sum_add;
        logic id_load;
        logic len_load;
        logic data_wr;
        logic emit_start;
        logic emit_issue;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync1_match;
        logic sync2_match;
        logic len_ok;
        logic len_zero;
        logic fill_last;
        logic sum_match;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/framed_packet_receiver_sum8.sv @@
// ----------------------------------------------------------------------------
// framed_packet_receiver_sum8
// Byte-serial receiver for sync/sync/id/length/payload/sum8 frames that
// replays each packet with a good checksum as one result per payload byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Carries
//  in       input      in_valid/in_stall   one received byte or a timeout
//  out      output     out_valid/out_stall one payload byte of a good packet
//  cfg      input      cfg_we              sync_first / sync_second write
//
//  Every input request is taken without a stall while a frame is parsed.
//  A good checksum byte starts a replay of max(1, length) results, read one
//  at a time through the single read port of the payload store; in_stall is
//  high for that whole replay. A stalled output holds the replay in place.
//  Reset is asynchronous and active low and returns to hunting for sync.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_sum8
#(
    parameter int MAX_PAYLOAD = frs8_pkg::MAX_PAYLOAD_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire frs8_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output frs8_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_data
);
    import frs8_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    frs8_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd),
        .state    (state)
    );

    frs8_dp
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (in_data.rx_byte),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // A timeout request always sends the parser back to hunting.
    a_timeout_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.req_type == REQ_TIMEOUT)
        |=> state == ST_HUNT1)
        else $error("timeout did not return parser to sync hunt");

    // The final replayed result ends the replay.
    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_issue && status.emit_last |=> state == ST_HUNT1)
        else $error("replay continued past its last result");

    // A replay only starts from the checksum phase on a matching byte.
    a_emit_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |-> (state == ST_SUM) && status.sum_match)
        else $error("replay started without a good checksum");

endmodule

`default_nettype wire

@@ hdl/frs8_ctrl.sv @@
// ----------------------------------------------------------------------------
// frs8_ctrl
// Frame parsing state machine; drives datapath commands and input stall.
// ----------------------------------------------------------------------------
`default_nettype none

module frs8_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              req_type,
    input  wire frs8_pkg::status_t status,
    output logic                   in_stall,
    output frs8_pkg::cmd_t         cmd,
    output frs8_pkg::state_t       state
);
    import frs8_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   byte_acc;
    logic   tmo_acc;

    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_stall   = (state_reg == ST_EMIT);
        byte_acc   = in_valid && !in_stall && (req_type == REQ_BYTE);
        tmo_acc    = in_valid && !in_stall && (req_type == REQ_TIMEOUT);
        cmd        = '0;
        state_next = state_reg;

        case (state_reg)
            ST_HUNT1:
            begin
                if (byte_acc)
                begin
                    cmd.sum_load = 1'b1;
                    state_next   = status.sync1_match ? ST_HUNT2 : ST_HUNT1;
                end
            end
            ST_HUNT2:
            begin
                if (byte_acc)
                begin
                    cmd.sum_add = 1'b1;
                    state_next  = status.sync2_match ? ST_ID : ST_HUNT1;
                end
            end
            ST_ID:
            begin
                if (byte_acc)
                begin
                    cmd.sum_add = 1'b1;
                    cmd.id_load = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (byte_acc)
                begin
                    if (status.len_ok)
                    begin
                        cmd.sum_add  = 1'b1;
                        cmd.len_load = 1'b1;
                        state_next   = status.len_zero ? ST_SUM : ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_DATA:
            begin
                if (byte_acc)
                begin
                    cmd.sum_add = 1'b1;
                    cmd.data_wr = 1'b1;
                    if (status.fill_last)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (byte_acc)
                begin
                    if (status.sum_match)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_issue = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT1;
            end
        endcase

        // A timeout drops whatever frame is in progress.
        if (tmo_acc)
        begin
            state_next = ST_HUNT1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/frs8_dp.sv @@
// ----------------------------------------------------------------------------
// frs8_dp
// Datapath: sync registers, running checksum, header fields, payload store
// and the output register that replays a good packet.
// ----------------------------------------------------------------------------
`default_nettype none

module frs8_dp
#(
    parameter int MAX_PAYLOAD = frs8_pkg::MAX_PAYLOAD_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         rx_byte,
    input  wire frs8_pkg::cmd_t     cmd,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               out_stall,
    output frs8_pkg::status_t       status,
    output logic                    out_valid,
    output frs8_pkg::out_item_t     out_data
);
    import frs8_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]       sync_first_reg;
    logic [7:0]       sync_second_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       msg_id_reg;
    logic [LEN_W-1:0] held_len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] emit_k_reg;

    logic [7:0]       mem [MAX_PAYLOAD];
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg;
    logic [7:0]       out_id_reg;
    logic [4:0]       out_len_reg;
    logic [4:0]       out_idx_reg;
    logic             out_last_reg;

    logic [LEN_W+4:0] len_ext;
    logic [LEN_W+4:0] k_ext;
    logic [LEN_W:0]   fill_inc;
    logic [LEN_W:0]   k_inc;

    assign len_ext  = {5'b0, held_len_reg};
    assign k_ext    = {5'b0, emit_k_reg};
    assign fill_inc = {1'b0, fill_reg} + 1'b1;
    assign k_inc    = {1'b0, emit_k_reg} + 1'b1;

    always_comb
    begin
        status.sync1_match = (rx_byte == sync_first_reg);
        status.sync2_match = (rx_byte == sync_second_reg);
        status.len_ok      = (rx_byte <= 8'(MAX_PAYLOAD));
        status.len_zero    = (rx_byte == 8'd0);
        status.fill_last   = (fill_inc >= {1'b0, held_len_reg});
        status.sum_match   = (rx_byte == sum_reg);
        status.out_free    = !out_valid_reg || !out_stall;
        status.emit_last   = (k_inc >= {1'b0, held_len_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            sum_reg         <= '0;
            msg_id_reg      <= '0;
            held_len_reg    <= '0;
            fill_reg        <= '0;
            emit_k_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_SYNC_FIRST))
            begin
                sync_first_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_SYNC_SECOND))
            begin
                sync_second_reg <= cfg_data;
            end

            if (cmd.sum_load)
            begin
                sum_reg <= rx_byte;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_reg + rx_byte;
            end

            if (cmd.id_load)
            begin
                msg_id_reg <= rx_byte;
            end

            if (cmd.len_load)
            begin
                held_len_reg <= rx_byte[LEN_W-1:0];
                fill_reg     <= '0;
            end
            else if (cmd.data_wr)
            begin
                fill_reg <= fill_inc[LEN_W-1:0];
            end

            if (cmd.emit_start)
            begin
                emit_k_reg <= '0;
            end
            else if (cmd.emit_issue)
            begin
                emit_k_reg <= k_inc[LEN_W-1:0];
            end

            if (cmd.emit_issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload store: written while filling, read once per replayed result.
    always_ff @(posedge clk)
    begin
        if (cmd.data_wr)
        begin
            mem[fill_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    // The read data register doubles as the payload field of the output stage.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_issue)
        begin
            rd_data_reg  <= (held_len_reg == '0) ? 8'd0 : mem[emit_k_reg[IDX_W-1:0]];
            out_id_reg   <= msg_id_reg;
            out_len_reg  <= len_ext[4:0];
            out_idx_reg  <= k_ext[4:0];
            out_last_reg <= status.emit_last;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.msg_id       = out_id_reg;
    assign out_data.payload_len  = out_len_reg;
    assign out_data.byte_index   = out_idx_reg;
    assign out_data.payload_byte = rd_data_reg;
    assign out_data.last         = out_last_reg;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for framed_packet_receiver_sum8. A cycle-free model of
// the frame parser tracks every accepted request and queues the payload
// bytes that a good checksum should replay; a monitor compares each replayed
// result against that queue while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import frs8_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = CFG_SYNC_FIRST;
    logic [7:0] cfg_data = 8'h00;

    // Bench knobs shared by the tests and the output stall process.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_hold = 0;
    int requests_sent = 0;
    int mismatch_count = 0;

    // Parser shadow: sync registers, frame fields, running sum and payload copy.
    logic [7:0] sync_first_q = SYNC_FIRST_RST;
    logic [7:0] sync_second_q = SYNC_SECOND_RST;
    state_t     parse_q = ST_HUNT1;
    logic [7:0] held_id = '0;
    logic [4:0] held_len = '0;
    logic [4:0] fill_pos = '0;
    logic [7:0] frame_sum = '0;
    logic [7:0] payload_copy [MAX_PAYLOAD_DEF];

    out_item_t expected_bytes [$];

    framed_packet_receiver_sum8 u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("framed_packet_receiver_sum8: mismatch");
        $finish;
    end

    // Advances the parser shadow by one accepted request and queues the
    // packet replay when the checksum byte matches.
    function automatic void track_frame(input in_item_t rq);
        logic [7:0] c;
        out_item_t  item;
        c = rq.rx_byte;
        if (rq.req_type == REQ_TIMEOUT)
        begin
            parse_q = ST_HUNT1;
            return;
        end
        case (parse_q)
            ST_HUNT2:
            begin
                parse_q = (c == sync_second_q) ? ST_ID : ST_HUNT1;
                frame_sum = frame_sum + c;
            end
            ST_ID:
            begin
                held_id = c;
                parse_q = ST_LEN;
                frame_sum = frame_sum + c;
            end
            ST_LEN:
            begin
                if (c <= MAX_PAYLOAD_DEF)
                begin
                    held_len = c[4:0];
                    fill_pos = '0;
                    parse_q = (c != 0) ? ST_DATA : ST_SUM;
                    frame_sum = frame_sum + c;
                end
                else
                begin
                    parse_q = ST_HUNT1;
                end
            end
            ST_DATA:
            begin
                payload_copy[fill_pos] = c;
                fill_pos = fill_pos + 1'b1;
                frame_sum = frame_sum + c;
                if (fill_pos >= held_len)
                    parse_q = ST_SUM;
            end
            ST_SUM:
            begin
                if (frame_sum == c)
                begin
                    if (held_len == 0)
                    begin
                        item = '{msg_id: held_id, payload_len: 5'd0, byte_index: 5'd0,
                                 payload_byte: 8'h00, last: 1'b1};
                        expected_bytes.push_back(item);
                    end
                    for (int k = 0; k < held_len; k++)
                    begin
                        item.msg_id       = held_id;
                        item.payload_len  = held_len;
                        item.byte_index   = k[4:0];
                        item.payload_byte = payload_copy[k];
                        item.last         = (k == held_len - 1);
                        expected_bytes.push_back(item);
                    end
                end
                parse_q = ST_HUNT1;
            end
            default:
            begin
                // The running sum restarts on every hunted byte, matched or not.
                parse_q = (c == sync_first_q) ? ST_HUNT2 : ST_HUNT1;
                frame_sum = c;
            end
        endcase
    endfunction

    // Receiver side: random stalls, or a forced hold-off while stall_hold runs.
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall <= 1'b1;
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("result error: unexpected id=%0h len=%0d idx=%0d byte=%0h last=%0b",
                             out_data.msg_id, out_data.payload_len, out_data.byte_index,
                             out_data.payload_byte, out_data.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.msg_id !== want.msg_id
                    || out_data.payload_len !== want.payload_len
                    || out_data.byte_index !== want.byte_index
                    || out_data.payload_byte !== want.payload_byte
                    || out_data.last !== want.last)
                begin
                    if (mismatch_count < 10)
                        $display({"result error: expected id=%0h len=%0d idx=%0d byte=%0h ",
                                  "last=%0b, got id=%0h len=%0d idx=%0d byte=%0h last=%0b"},
                                 want.msg_id, want.payload_len, want.byte_index,
                                 want.payload_byte, want.last, out_data.msg_id,
                                 out_data.payload_len, out_data.byte_index,
                                 out_data.payload_byte, out_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Offers one request, idling first at random, and returns once it is taken.
    task automatic send_request(input logic kind, input logic [7:0] value);
        in_item_t rq;
        rq.req_type = kind;
        rq.rx_byte = value;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = rq;
        do
            @(posedge clk);
        while (in_stall);
        track_frame(rq);
        requests_sent++;
    endtask

    // Sends a complete frame; fill below zero picks random payload bytes.
    task automatic send_frame(input logic [7:0] id, input int len, input bit good_sum,
                              input int fill);
        logic [7:0] chk;
        logic [7:0] b;
        chk = sync_first_q + sync_second_q + id + len[7:0];
        send_request(REQ_BYTE, sync_first_q);
        send_request(REQ_BYTE, sync_second_q);
        send_request(REQ_BYTE, id);
        send_request(REQ_BYTE, len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom) : fill[7:0];
            chk = chk + b;
            send_request(REQ_BYTE, b);
        end
        if (!good_sum)
            chk = chk ^ (8'h01 << $urandom_range(7));
        send_request(REQ_BYTE, chk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        if (idx == CFG_SYNC_FIRST)
            sync_first_q = value;
        else
            sync_second_q = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_frame(8'h00, 0, 1'b1, 0);
        send_frame(8'hFF, 1, 1'b1, 255);
        // A length one past the limit sends the parser back to hunting.
        send_request(REQ_BYTE, sync_first_q);
        send_request(REQ_BYTE, sync_second_q);
        send_request(REQ_BYTE, 8'h11);
        send_request(REQ_BYTE, 8'd31);
        send_request(REQ_BYTE, sync_first_q);
        send_request(REQ_BYTE, 8'h00);
        // The byte field of a timeout request is ignored.
        send_request(REQ_BYTE, sync_first_q);
        send_request(REQ_BYTE, sync_second_q);
        send_request(REQ_TIMEOUT, 8'hFF);
        send_frame(8'h42, 0, 1'b0, 0);
        wait_drain();
    endtask

    task automatic test_sync_settings();
        logic [7:0] firsts [4] = '{8'h00, 8'hFF, 8'h5A, SYNC_FIRST_RST};
        logic [7:0] seconds [4] = '{8'hFF, 8'h00, 8'h5A, SYNC_SECOND_RST};
        send_idle_pct = 20;
        recv_stall_pct = 20;
        for (int i = 0; i < 4; i++)
        begin
            write_sync(CFG_SYNC_FIRST, firsts[i]);
            write_sync(CFG_SYNC_SECOND, seconds[i]);
            send_request(REQ_BYTE, 8'($urandom));
            send_request(REQ_TIMEOUT, 8'($urandom));
            send_frame(8'($urandom), $urandom_range(1, 4), 1'b1, -1);
            send_frame(8'($urandom), 0, 1'b1, 0);
            wait_drain();
        end
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int n_req);
        int stop_at;
        int pick;
        int len;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = requests_sent + n_req;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                len = $urandom_range(9);
                if (len < 6)
                    len = $urandom_range(0, 6);
                else if (len < 9)
                    len = $urandom_range(7, MAX_PAYLOAD_DEF - 1);
                else
                    len = MAX_PAYLOAD_DEF;
                send_frame(8'($urandom), len, $urandom_range(7) != 0, -1);
            end
            else if (pick < 82)
            begin
                send_request(REQ_BYTE, 8'($urandom));
            end
            else if (pick < 88)
            begin
                send_request(REQ_TIMEOUT, 8'($urandom));
            end
            else if (pick < 93)
            begin
                send_request(REQ_BYTE, sync_first_q);
                send_request(REQ_BYTE, sync_second_q);
                send_request(REQ_BYTE, 8'($urandom));
                send_request(REQ_BYTE, 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
            end
            else if (pick < 97)
            begin
                // Frame cut short by a receive timeout part way through.
                send_request(REQ_BYTE, sync_first_q);
                send_request(REQ_BYTE, sync_second_q);
                send_request(REQ_BYTE, 8'($urandom));
                send_request(REQ_BYTE, 8'($urandom_range(1, 8)));
                send_request(REQ_BYTE, 8'($urandom));
                send_request(REQ_TIMEOUT, 8'($urandom));
            end
            else
            begin
                send_request(REQ_BYTE, sync_first_q);
                send_request(REQ_BYTE, 8'($urandom));
            end
        end
        wait_drain();
    endtask

    // The receiver holds off while full-size packets keep arriving, so the
    // replay backs up and the block stalls its request input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 20;
        @(posedge clk);
        stall_hold = 150;
        send_frame(8'($urandom), MAX_PAYLOAD_DEF, 1'b1, -1);
        send_frame(8'($urandom), MAX_PAYLOAD_DEF, 1'b1, -1);
        send_frame(8'($urandom), 3, 1'b1, -1);
        wait_drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_sync_settings();
        test_random(9, 55, 20);
        test_random(55, 9, 20);
        test_random(0, 0, 20);
        test_backpressure();
        if (mismatch_count == 0)
            $display("framed_packet_receiver_sum8: match");
        else
            $display("framed_packet_receiver_sum8: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
